### rtl/bvs_pkg.sv
// shared types, constants and codes for the bounded vector store
package bvs_pkg;

    localparam int DEPTH  = 256;
    localparam int WORD_W = 32;
    localparam int IDX_W  = 8;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 9;
    localparam int POS_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH     = 3'd0,
        FN_SET      = 3'd1,
        FN_GET      = 3'd2,
        FN_REMOVE   = 3'd3,
        FN_POP      = 3'd4,
        FN_CLEAR    = 3'd5
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  index;
        logic [WORD_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] read_value;
        logic [CNT_W-1:0]  count;
    } rsp_t;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic              wr_en;
        logic [POS_W-1:0]  wr_pos;
        logic [WORD_W-1:0] wr_word;
        logic              sh_en;
        logic [POS_W-1:0]  sh_lo;
        logic [POS_W-1:0]  sh_hi;
        logic [POS_W-1:0]  rd_pos;
    } cell_ctl_t;

endpackage

### rtl/bvs_cell.sv
// one storage cell of the row: holds one word, loads or takes its upper neighbor
module bvs_cell
    import bvs_pkg::*;
(
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic [POS_W-1:0]  pos,
    input  logic [WORD_W-1:0] up_word,
    output logic [WORD_W-1:0] word,
    output logic [WORD_W-1:0] rd_word
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic              shift_hit;

    assign shift_hit = ctl.sh_en && (pos >= ctl.sh_lo) && (pos < ctl.sh_hi);

    always_comb
    begin
        word_next = word_reg;
        if (shift_hit)
        begin
            word_next = up_word;
        end
        else if (ctl.wr_en && (pos == ctl.wr_pos))
        begin
            word_next = ctl.wr_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    assign rd_word = (pos == ctl.rd_pos) ? word_reg : '0;

endmodule

### rtl/bvs_ctrl.sv
// request sequencer: decodes one request, drives the cell row, keeps the count
module bvs_ctrl
    import bvs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  req_t              request,
    input  logic [WORD_W-1:0] row_word,
    output logic              busy,
    output cell_ctl_t         ctl,
    output logic              done,
    output rsp_t              result
);

    state_t            state_reg;
    state_t            state_next;
    req_t              req_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              done_reg;
    logic              done_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    logic [CMP_W-1:0]  idx_cmp;
    logic [CMP_W-1:0]  cnt_cmp;
    logic              idx_ok;
    logic              full;
    logic              empty;
    logic [POS_W-1:0]  idx_pos;
    logic [POS_W-1:0]  last_pos;
    logic [CNT_W-1:0]  cnt_dec;

    assign idx_cmp  = CMP_W'(req_reg.index);
    assign cnt_cmp  = CMP_W'(count_reg);
    assign idx_ok   = idx_cmp < cnt_cmp;
    assign full     = count_reg >= CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign idx_pos  = POS_W'(idx_cmp);
    assign cnt_dec  = count_reg - CNT_W'(1);
    assign last_pos = POS_W'(cnt_dec);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        ctl.wr_en       = 1'b0;
        ctl.wr_pos      = idx_pos;
        ctl.wr_word     = req_reg.value;
        ctl.sh_en       = 1'b0;
        ctl.sh_lo       = idx_pos;
        ctl.sh_hi       = last_pos;
        ctl.rd_pos      = idx_pos;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next          = S_IDLE;
                done_next           = 1'b1;
                rsp_next.status     = ST_OK;
                rsp_next.read_value = '0;
                case (req_reg.func)
                    FN_PUSH:
                    begin
                        if (full)
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            ctl.wr_en  = 1'b1;
                            ctl.wr_pos = POS_W'(count_reg);
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    FN_SET:
                    begin
                        if (!idx_ok)
                        begin
                            rsp_next.status = ST_RANGE;
                        end
                        else
                        begin
                            ctl.wr_en = 1'b1;
                        end
                    end
                    FN_GET:
                    begin
                        if (!idx_ok)
                        begin
                            rsp_next.status = ST_RANGE;
                        end
                        else
                        begin
                            rsp_next.read_value = row_word;
                        end
                    end
                    FN_REMOVE:
                    begin
                        if (!idx_ok)
                        begin
                            rsp_next.status = ST_RANGE;
                        end
                        else
                        begin
                            rsp_next.read_value = row_word;
                            ctl.sh_en           = 1'b1;
                            count_next          = cnt_dec;
                        end
                    end
                    FN_POP:
                    begin
                        ctl.rd_pos = last_pos;
                        if (empty)
                        begin
                            rsp_next.status = ST_RANGE;
                        end
                        else
                        begin
                            rsp_next.read_value = row_word;
                            count_next          = cnt_dec;
                        end
                    end
                    FN_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        // unused codes leave everything alone
                    end
                endcase
                rsp_next.count = count_next;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (state_reg == S_IDLE && start)
        begin
            req_reg <= request;
        end
    end

    assign busy   = state_reg == S_EXEC;
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

### rtl/bounded_vector_store_core.sv
// top level of the bounded vector store: request sequencer and the row of cells
//
// A bounded list of 32-bit words with a live count, held in a row of DEPTH
// cells, one word per cell. A request is taken when start is high and busy is
// low; every request gives exactly one result, shown on result for one cycle
// with done high, and it must be taken in that cycle: there is no way to hold
// it off. A request is captured in the cycle it is accepted in; in the
// execute cycle, the row is read through a select tree and updated (write,
// or every later cell taking the word of its upper neighbor on remove at
// index) and the result is registered. busy is high during the execute
// cycle, so a new request can be offered while the previous result is on
// the ports, but none is taken while the previous one executes. Cell
// contents need no clearing after reset: only live entries are ever read,
// and those have been written.
module bounded_vector_store_core
    import bvs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t request,
    output logic busy,
    output logic done,
    output rsp_t result
);

    cell_ctl_t         ctl;
    logic [WORD_W-1:0] cell_word [DEPTH];
    logic [WORD_W-1:0] cell_rd   [DEPTH];
    logic [WORD_W-1:0] up_word   [DEPTH];
    logic [WORD_W-1:0] row_word;

    // sequencer: decode, range checks and live count
    bvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .row_word (row_word),
        .busy     (busy),
        .ctl      (ctl),
        .done     (done),
        .result   (result)
    );

    // row of cells, each below the top fed by its upper neighbor for the shift-down
    for (genvar p = 0; p < DEPTH; p++)
    begin : g_cell
        if (p == DEPTH - 1)
        begin : g_top
            // the last cell never shifts, it is never below the shift limit
            assign up_word[p] = cell_word[p];
        end
        else
        begin : g_mid
            assign up_word[p] = cell_word[p+1];
        end

        bvs_cell u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .pos     (POS_W'(p)),
            .up_word (up_word[p]),
            .word    (cell_word[p]),
            .rd_word (cell_rd[p])
        );
    end

    // read select: each cell gates its own word, the row is or-ed together
    always_comb
    begin
        row_word = '0;
        for (int p = 0; p < DEPTH; p++)
        begin
            row_word = row_word | cell_rd[p];
        end
    end

endmodule

### rtl/bvs_checker.sv
// port-level checks for the bounded vector store, bound to the top level
module bvs_checker
    import bvs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input req_t request,
    input logic busy,
    input logic done,
    input rsp_t result
);

    // an accepted request is executed in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request not executed");

    // execute ends with busy low and a result in the next cycle
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (!busy && done))
        else $error("execute cycle did not produce a result");

    // no result without a preceding execute cycle
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without request");

    // full is reported only when the count is at capacity
    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FULL) |-> (result.count == CNT_W'(DEPTH)))
        else $error("full reported below capacity");

    // a failing request reads nothing
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |-> (result.read_value == '0))
        else $error("failed request returned data");

endmodule

bind bounded_vector_store_core bvs_checker u_bvs_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
);

### bench/tb_bounded_vector_store_core.sv
// self-checking testbench for bounded_vector_store_core: predicted results vs. result strobes
module tb_bounded_vector_store_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bvs_pkg::*;

    // func codes the block decodes as no-ops
    localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    localparam int REQ_W        = $bits(req_t);
    localparam int RANDOM_ITEMS = 1350;
    // last stretch of the random part, sent back to back with no gaps
    localparam int TAIL_ITEMS   = 150;
    // extra wait after the last result before the final verdict
    localparam int DRAIN_CYCLES = 10;
    // watchdog bound, many times the length of the slowest legal run
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int PRINT_CAP    = 40;

    // shadow copy of the list plus the queue of results still owed by the block
    class vector_store_scoreboard;
        logic [WORD_W-1:0] shadow_words [DEPTH];
        logic [CNT_W-1:0]  live_words;
        rsp_t              awaited_rsp [$];
        int                mismatches;

        function new();
            live_words = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return awaited_rsp.size();
        endfunction

        // apply one accepted item to the shadow list and queue the result it owes
        function void note_request(req_t r);
            rsp_t exp_rsp;
            int   k;
            exp_rsp.status     = ST_OK;
            exp_rsp.read_value = '0;
            case (r.func)
                FN_PUSH:
                    if (live_words >= DEPTH)
                        exp_rsp.status = ST_FULL;
                    else
                    begin
                        shadow_words[POS_W'(live_words)] = r.value;
                        live_words++;
                    end
                FN_SET:
                    if (r.index >= live_words)
                        exp_rsp.status = ST_RANGE;
                    else
                        shadow_words[r.index] = r.value;
                FN_GET:
                    if (r.index >= live_words)
                        exp_rsp.status = ST_RANGE;
                    else
                        exp_rsp.read_value = shadow_words[r.index];
                FN_REMOVE:
                    if (r.index >= live_words)
                        exp_rsp.status = ST_RANGE;
                    else
                    begin
                        exp_rsp.read_value = shadow_words[r.index];
                        for (k = r.index; k + 1 < live_words; k++)
                            shadow_words[k] = shadow_words[k + 1];
                        live_words--;
                    end
                FN_POP:
                    if (live_words == 0)
                        exp_rsp.status = ST_RANGE;
                    else
                    begin
                        exp_rsp.read_value = shadow_words[POS_W'(live_words - CNT_W'(1))];
                        live_words--;
                    end
                FN_CLEAR:
                    live_words = '0;
                default:
                    ;
            endcase
            exp_rsp.count = live_words;
            awaited_rsp.push_back(exp_rsp);
        endfunction

        task report(string msg);
            if (mismatches < PRINT_CAP)
                $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(rsp_t got);
            rsp_t want;
            if (awaited_rsp.size() == 0)
            begin
                report($sformatf("unexpected result status=%0d word=%h count=%0d",
                                 got.status, got.read_value, got.count));
                return;
            end
            want = awaited_rsp.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, predicted %0d", got.status, want.status));
            if (got.read_value !== want.read_value)
                report($sformatf("read_value %h, predicted %h",
                                 got.read_value, want.read_value));
            if (got.count !== want.count)
                report($sformatf("count %0d, predicted %0d", got.count, want.count));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic start;
    req_t request;
    logic busy;
    logic done;
    rsp_t result;

    vector_store_scoreboard sb;

    // items sent so far, no-op codes included
    int issued_items;
    // chance in percent of a sender gap after each item
    int idle_pct;
    int cycle_count;

    bounded_vector_store_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: a hung handshake or a lost result ends here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // results cannot be held off, so every strobe is checked on the edge that ends it
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    // sender gap; request carries junk while start is low to show it is ignored
    task automatic idle_sender(int n);
        start   = 1'b0;
        request = REQ_W'({$urandom, $urandom});
        repeat (n) @(negedge clk);
    endtask

    // present one item from a falling edge and hold it until the block takes it
    task automatic issue(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] v);
        req_t r;
        r.func  = f;
        r.index = idx;
        r.value = v;
        request = r;
        start   = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(r);
        @(negedge clk);
        issued_items++;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            idle_sender($urandom_range(1, 12));
    endtask

    // stop offering items until the block has returned everything owed
    task automatic hold_until_drained();
        start = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // mostly live positions so set, get and remove do real work
    function automatic logic [IDX_W-1:0] pick_index();
        if (sb.live_words != 0 && $urandom_range(0, 9) < 8)
            return IDX_W'($urandom_range(0, sb.live_words - 1));
        return IDX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic mixed_ops(int n);
        int                sel;
        logic [FUNC_W-1:0] f;
        repeat (n)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 24)
                f = FN_PUSH;
            else if (sel < 38)
                f = FN_SET;
            else if (sel < 56)
                f = FN_GET;
            else if (sel < 70)
                f = FN_REMOVE;
            else if (sel < 84)
                f = FN_POP;
            else if (sel < 88)
                f = FN_CLEAR;
            else if (sel < 94)
                f = $urandom_range(0, 1) ? FN_SPARE_HI : FN_SPARE_LO;
            else
                f = FN_PUSH;
            issue(f, pick_index(), pick_word());
        end
    endtask

    // fully random fields, including the no-op codes
    task automatic noise_ops(int n);
        repeat (n)
            issue(FUNC_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 255)), $urandom);
    endtask

    // fill to capacity, then poke both ends of a full row
    task automatic fill_and_work();
        while (sb.live_words < DEPTH)
            issue(FN_PUSH, IDX_W'($urandom_range(0, 255)), pick_word());
        issue(FN_PUSH, IDX_W'($urandom_range(0, 255)), pick_word());
        issue(FN_PUSH, IDX_W'($urandom_range(0, 255)), '1);
        issue(FN_GET, 8'd255, $urandom);
        issue(FN_SET, 8'd255, pick_word());
        issue(FN_REMOVE, 8'd255, $urandom);
        issue(FN_PUSH, 8'd0, pick_word());
        // shift the entire row down by one
        issue(FN_REMOVE, 8'd0, $urandom);
        issue(FN_GET, 8'd0, $urandom);
        issue(FN_PUSH, IDX_W'($urandom_range(0, 255)), pick_word());
        issue(FN_GET, 8'd255, $urandom);
        mixed_ops($urandom_range(20, 40));
    endtask

    // pop until empty, then one pop too many
    task automatic drain_all();
        while (sb.live_words != 0)
            issue(FN_POP, IDX_W'($urandom_range(0, 255)), $urandom);
        issue(FN_POP, IDX_W'($urandom_range(0, 255)), $urandom);
    endtask

    task automatic directed_items();
        // everything on an empty list is out of range
        issue(FN_POP, 8'd0, '0);
        issue(FN_GET, 8'd0, '0);
        issue(FN_SET, 8'd0, 32'h1111_1111);
        issue(FN_REMOVE, 8'd0, '0);
        issue(FN_PUSH, 8'd0, 32'h0000_0000);
        issue(FN_PUSH, 8'hff, 32'hffff_ffff);
        issue(FN_PUSH, 8'h55, 32'ha5a5_a5a5);
        issue(FN_PUSH, 8'haa, 32'h5a5a_5a5a);
        issue(FN_GET, 8'd0, '0);
        issue(FN_GET, 8'd3, '1);
        // index equal to count, and the top of the index range
        issue(FN_GET, 8'd4, '0);
        issue(FN_GET, 8'd255, '0);
        issue(FN_SET, 8'd1, 32'h1234_5678);
        issue(FN_SET, 8'd255, 32'hdead_0000);
        // remove from the middle, later entries move down
        issue(FN_REMOVE, 8'd1, '0);
        issue(FN_REMOVE, 8'd3, '0);
        issue(FN_REMOVE, 8'd0, '1);
        issue(FN_SPARE_LO, IDX_W'($urandom_range(0, 255)), $urandom);
        issue(FN_SPARE_HI, 8'hff, '1);
        issue(FN_POP, 8'd0, '0);
        issue(FN_POP, 8'd0, '0);
        issue(FN_POP, 8'd0, '0);
        issue(FN_PUSH, 8'd0, 32'hdead_beef);
        // clear keeps the word but it is no longer readable
        issue(FN_CLEAR, 8'd0, '0);
        issue(FN_GET, 8'd0, '0);
    endtask

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        idle_pct     = 0;
        issued_items = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        idle_pct = 20;
        directed_items();

        // random part: at least one trip through a full list first
        idle_pct     = 25;
        fill_and_work();
        hold_until_drained();
        drain_all();

        while (issued_items < RANDOM_ITEMS - TAIL_ITEMS)
        begin
            // some episodes run back to back, others with frequent gaps
            idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: mixed_ops($urandom_range(20, 60));
                5: fill_and_work();
                6: drain_all();
                7: noise_ops($urandom_range(5, 20));
                default:
                begin
                    issue(FN_CLEAR, IDX_W'($urandom_range(0, 255)), $urandom);
                    mixed_ops($urandom_range(10, 30));
                end
            endcase
            if ($urandom_range(0, 15) == 0)
                hold_until_drained();
        end

        // closing stretch at full rate
        idle_pct = 0;
        mixed_ops(TAIL_ITEMS);
        start = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
